### rtl/assert_macros.svh
// assertion macros for the fec window loss tracker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define FWLT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define FWLT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define FWLT_ASSERT(lbl, prop, msg)
`define FWLT_NEVER(lbl, cond, msg)
`endif

`endif

### rtl/fwlt_pkg.sv
// types and constants of the fec window loss tracker
package fwlt_pkg;

	localparam int SEQ_W      = 24;
	localparam int LEN_W      = 16;
	localparam int SEG_W      = 16;
	localparam int WIN_W      = 8;
	localparam int IMG_W      = 24;
	localparam int SPAN_W     = 24;
	localparam int CNT_W      = 16;
	localparam int ACT_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [SEG_W-1:0] SEG_RST = 16'd1024;
	localparam logic [WIN_W-1:0] WIN_RST = 8'd4;
	localparam logic [IMG_W-1:0] IMG_RST = 24'd0;

	localparam logic [CFG_IDX_W-1:0] REG_SEGMENT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE   = 2'd2;

	typedef enum logic [ACT_W-1:0] {
		ACT_DATA    = 2'd0,
		ACT_NOREC   = 2'd1,
		ACT_RECOVER = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV1,
		ST_POST1,
		ST_DIV2,
		ST_POST2,
		ST_FIN
	} state_t;

endpackage

### rtl/fec_window_loss_tracker.sv
// fec window loss tracker: packet header accounting and parity recovery commands
// a beat is taken only while idle; the next one waits until the last result is loaded
// data beats run one division by the window span, parity beats a second one by segment size
// the bit-serial restoring divider gives one quotient bit a cycle
// reset: config to 1024 / 4 / 0, window state cleared, no beat pending
`include "assert_macros.svh"

module fec_window_loss_tracker import fwlt_pkg::*; #(
	parameter int OFFSET_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  opcode,
	input  logic [SEQ_W-1:0]      seq_offset,
	input  logic [LEN_W-1:0]      seg_length,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ACT_W-1:0]      action,
	output logic [SEQ_W-1:0]      window_start,
	output logic [SEQ_W-1:0]      window_end,
	output logic [SEQ_W-1:0]      lost_offset,
	output logic [LEN_W-1:0]      lost_length
);

	localparam int OW   = OFFSET_BITS;
	localparam int CW   = (OW > SEQ_W) ? OW : SEQ_W;
	localparam int QW   = (OW > CNT_W + 1) ? OW : CNT_W + 1;
	localparam int CNTW = $clog2(OW);

	state_t state_q, state_d;

	logic [SEG_W-1:0] seg_q;
	logic [WIN_W-1:0] win_q;
	logic [IMG_W-1:0] img_q;

	logic [OW-1:0]    head_q, fl_q, exp_q;
	logic [CNT_W-1:0] count_q;

	logic             op_q;
	logic [OW-1:0]    seq_q;
	logic [LEN_W-1:0] len_q;

	logic [OW-1:0]     dvd_q;
	logic [SPAN_W-1:0] rem_q, dsr_q;
	logic [CNTW-1:0]   div_cnt_q;

	action_t          res_act_q;
	logic [SEQ_W-1:0] res_ws_q, res_we_q, res_lo_q;
	logic [LEN_W-1:0] res_ll_q;

	logic             out_valid_q;
	logic [ACT_W-1:0] action_q;
	logic [SEQ_W-1:0] ws_q, we_q, lo_q;
	logic [LEN_W-1:0] ll_q;

	logic              out_load, div_run, div_last;
	logic [SPAN_W:0]   trial, trial_sub;
	logic              trial_ge;
	logic [SPAN_W-1:0] rem_next;

	logic             div_zero, num_is0, num_is1, num_gt1, rem_nz, realign, recover;
	logic [OW-1:0]    rem_ow, span_ow, diff, seq_mr, seq_ms, head_new;
	logic [OW-1:0]    p_head, p_fl, diff2, exp_sat;
	logic [OW:0]      sum_w;
	logic [CNT_W-1:0] cnt_inc;
	logic [QW-1:0]    q2x, cnt_x, cnt_x1;
	logic [CW-1:0]    flx, imx, segx, left;
	logic [LEN_W-1:0] ll_val;

	// serial divider step
	assign trial     = {rem_q, dvd_q[OW-1]};
	assign trial_sub = trial - {1'b0, dsr_q};
	assign trial_ge  = trial >= {1'b0, dsr_q};
	assign rem_next  = trial_ge ? trial_sub[SPAN_W-1:0] : trial[SPAN_W-1:0];
	assign div_last  = div_cnt_q == CNTW'(OW - 1);

	// quotient and remainder of the finished division
	assign div_zero = dsr_q == '0;
	assign num_is0  = div_zero || dvd_q == '0;
	assign num_is1  = !div_zero && dvd_q == OW'(1);
	assign num_gt1  = !div_zero && dvd_q[OW-1:1] != '0;
	assign rem_nz   = !div_zero && rem_q != '0;
	assign rem_ow   = OW'(rem_q);
	assign span_ow  = OW'(dsr_q);

	assign diff    = (seq_q >= head_q) ? seq_q - head_q : '0;
	assign seq_mr  = seq_q - rem_ow;
	assign seq_ms  = seq_q - span_ow;
	assign sum_w   = {1'b0, seq_q} + (OW+1)'(len_q);
	assign exp_sat = sum_w[OW] ? '1 : sum_w[OW-1:0];
	assign cnt_inc = (count_q == '1) ? count_q : count_q + CNT_W'(1);

	// parity realignment by whole windows
	assign realign  = num_gt1 || (num_is1 && rem_nz);
	assign head_new = rem_nz ? seq_mr : seq_ms;
	assign p_head   = realign ? head_new : head_q;
	assign p_fl     = realign ? head_new : ((seq_q != exp_q) ? exp_q : fl_q);
	assign diff2    = (seq_q >= p_head) ? seq_q - p_head : '0;

	// exactly one missing segment check
	assign q2x     = QW'(dvd_q);
	assign cnt_x   = QW'(count_q);
	assign cnt_x1  = cnt_x + QW'(1);
	assign recover = !div_zero &&
		((rem_q != '0) ? (q2x == cnt_x) : (q2x != '0 && q2x == cnt_x1));

	// lost length clipped at object end
	assign flx    = CW'(fl_q);
	assign imx    = CW'(img_q);
	assign segx   = CW'(seg_q);
	assign left   = imx - flx;
	assign ll_val = (flx < imx) ? ((left < segx) ? LEN_W'(left) : seg_q) : '0;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_PREP;
			ST_PREP:  state_d = ST_DIV1;
			ST_DIV1:  if (div_last) state_d = ST_POST1;
			ST_POST1: state_d = op_q ? ST_DIV2 : ST_FIN;
			ST_DIV2:  if (div_last) state_d = ST_POST2;
			ST_POST2: state_d = ST_FIN;
			ST_FIN:   if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = state_q == ST_IDLE;
		div_run  = state_q == ST_DIV1 || state_q == ST_DIV2;
		out_load = state_q == ST_FIN && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			div_cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (div_run) begin
				div_cnt_q <= div_last ? '0 : div_cnt_q + CNTW'(1);
			end
		end
	end

	// configuration and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q   <= SEG_RST;
			win_q   <= WIN_RST;
			img_q   <= IMG_RST;
			head_q  <= '0;
			fl_q    <= '0;
			exp_q   <= '0;
			count_q <= '0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					REG_SEGMENT: seg_q <= cfg_data[SEG_W-1:0];
					REG_WINDOW:  win_q <= cfg_data[WIN_W-1:0];
					REG_IMAGE:   img_q <= cfg_data[IMG_W-1:0];
					default:     ;
				endcase
			end
			if (state_q == ST_POST1) begin
				if (!op_q) begin
					if (!num_is0) begin
						head_q <= seq_mr;
						if (rem_nz) begin
							fl_q <= seq_mr;
						end
					end else if (seq_q != exp_q) begin
						fl_q <= exp_q;
					end
					exp_q   <= exp_sat;
					count_q <= num_is0 ? cnt_inc : CNT_W'(1);
				end else begin
					head_q <= p_head;
					fl_q   <= p_fl;
					if (realign) begin
						count_q <= '0;
					end
				end
			end
			if (state_q == ST_POST2) begin
				count_q <= '0;
				fl_q    <= '0;
				head_q  <= seq_q;
				exp_q   <= seq_q;
			end
		end
	end

	// beat capture, divider and result registers
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_q  <= opcode;
			seq_q <= OW'(seq_offset);
			len_q <= seg_length;
		end
		if (state_q == ST_PREP) begin
			dvd_q <= diff;
			rem_q <= '0;
			dsr_q <= SPAN_W'(win_q) * SPAN_W'(seg_q);
		end
		if (div_run) begin
			dvd_q <= {dvd_q[OW-2:0], trial_ge};
			rem_q <= rem_next;
		end
		if (state_q == ST_POST1) begin
			if (op_q) begin
				dvd_q <= diff2;
				rem_q <= '0;
				dsr_q <= SPAN_W'(seg_q);
			end else begin
				res_act_q <= ACT_DATA;
				res_ws_q  <= '0;
				res_we_q  <= '0;
				res_lo_q  <= '0;
				res_ll_q  <= '0;
			end
		end
		if (state_q == ST_POST2) begin
			res_act_q <= recover ? ACT_RECOVER : ACT_NOREC;
			res_ws_q  <= SEQ_W'(head_q);
			res_we_q  <= SEQ_W'(seq_q);
			res_lo_q  <= recover ? SEQ_W'(fl_q) : '0;
			res_ll_q  <= recover ? ll_val : '0;
		end
		if (out_load) begin
			action_q <= res_act_q;
			ws_q     <= res_ws_q;
			we_q     <= res_we_q;
			lo_q     <= res_lo_q;
			ll_q     <= res_ll_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign action       = action_q;
	assign window_start = ws_q;
	assign window_end   = we_q;
	assign lost_offset  = lo_q;
	assign lost_length  = ll_q;

	`FWLT_ASSERT(a_accept_starts, in_valid && in_ready |=> state_q == ST_PREP, "beat taken outside idle")
	`FWLT_ASSERT(a_cnt_idle, !div_run |-> div_cnt_q == '0, "divider count left running")
	`FWLT_ASSERT(a_rem_bound, div_run && dsr_q != '0 |-> rem_q < dsr_q, "partial remainder too large")
	`FWLT_ASSERT(a_data_clean, out_valid && action == ACT_DATA |-> window_start == '0 && lost_length == '0, "data beat with window fields")
	`FWLT_NEVER(a_ll_bound, out_valid && action == ACT_RECOVER && lost_length > seg_q, "lost length beyond segment")

endmodule

### tb/tb_fec_window_loss_tracker.sv
// testbench for the fec window loss tracker: directed table then random packet streams, checked against a predictor
`timescale 1ns / 100ps

module tb_fec_window_loss_tracker import fwlt_pkg::*; ();

	localparam logic OP_DATA   = 1'b0;
	localparam logic OP_PARITY = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [63:0] OFF_MAX = (64'd1 << SEQ_W) - 64'd1;
	localparam int ITEM_TARGET = 1550;
	localparam int TAIL_CYCLES = 64;
	localparam int MAX_REPORTS = 30;

	typedef struct packed {
		action_t          act;
		logic [SEQ_W-1:0] win_start;
		logic [SEQ_W-1:0] win_end;
		logic [SEQ_W-1:0] lost_off;
		logic [LEN_W-1:0] lost_len;
	} loss_cmd_t;

	typedef enum logic {ROW_PACKET, ROW_CONFIG} row_kind_t;

	// for config rows: seq carries image_bytes, len segment_bytes
	typedef struct packed {
		row_kind_t        kind;
		logic             op;
		logic [SEQ_W-1:0] seq;
		logic [LEN_W-1:0] len;
		logic [WIN_W-1:0] win;
		logic             typed;
		loss_cmd_t        cmd;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_SEGMENT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  opcode = OP_DATA;
	logic [SEQ_W-1:0]      seq_offset = '0;
	logic [LEN_W-1:0]      seg_length = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [ACT_W-1:0]      action;
	logic [SEQ_W-1:0]      window_start;
	logic [SEQ_W-1:0]      window_end;
	logic [SEQ_W-1:0]      lost_offset;
	logic [LEN_W-1:0]      lost_length;

	logic      drv_typed = 1'b0;
	loss_cmd_t drv_cmd = '0;

	// predictor copy of the configuration and window state
	logic [SEG_W-1:0] cfg_seg = SEG_RST;
	logic [WIN_W-1:0] cfg_win = WIN_RST;
	logic [IMG_W-1:0] cfg_img = IMG_RST;
	logic [SEQ_W-1:0] trk_head = '0;
	logic [SEQ_W-1:0] trk_lost = '0;
	logic [SEQ_W-1:0] trk_next = '0;
	logic [CNT_W-1:0] trk_count = '0;

	loss_cmd_t loss_cmd_q[$];
	int n_sent = 0;
	int n_done = 0;
	int n_errors = 0;
	int n_recover = 0;
	int n_norec = 0;
	int n_settings = 0;
	bit in_calm = 1'b0;
	bit out_calm = 1'b0;

	fec_window_loss_tracker DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.seq_offset   (seq_offset),
		.seg_length   (seg_length),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.action       (action),
		.window_start (window_start),
		.window_end   (window_end),
		.lost_offset  (lost_offset),
		.lost_length  (lost_length)
	);

	always #2 clk = ~clk;

	function automatic loss_cmd_t next_loss_cmd(input logic op, input logic [SEQ_W-1:0] seq,
			input logic [LEN_W-1:0] len);
		logic [63:0] span, lag, whole, part, quo, frac, needed, left;
		loss_cmd_t cmd;
		cmd = '0;
		span = 64'(cfg_win) * 64'(cfg_seg);
		lag = (seq >= trk_head) ? 64'(seq - trk_head) : 64'd0;
		whole = '0;
		part = '0;
		if (span != 0) begin
			whole = lag / span;
			part = lag % span;
		end
		if (op == OP_DATA) begin
			if (whole != 0) begin
				trk_head = SEQ_W'(64'(trk_head) + whole * span);
				trk_count = '0;
				if (part != 0)
					trk_lost = trk_head;
			end else if (seq != trk_next) begin
				trk_lost = trk_next;
			end
			trk_next = (64'(seq) + 64'(len) > OFF_MAX) ? '1 : SEQ_W'(64'(seq) + 64'(len));
			if (trk_count != '1)
				trk_count = trk_count + CNT_W'(1);
			cmd.act = ACT_DATA;
		end else begin
			// missed parity beats: move on by whole windows
			if (whole > 1 || (whole == 1 && part != 0)) begin
				trk_head = SEQ_W'(64'(trk_head)
					+ span * (whole + ((part != 0) ? 64'd1 : 64'd0) - 64'd1));
				trk_lost = trk_head;
				trk_count = '0;
			end else if (seq != trk_next) begin
				trk_lost = trk_next;
			end
			lag = (seq >= trk_head) ? 64'(seq - trk_head) : 64'd0;
			quo = '0;
			frac = '0;
			if (cfg_seg != 0) begin
				quo = lag / 64'(cfg_seg);
				frac = lag % 64'(cfg_seg);
			end
			needed = quo + ((frac != 0) ? 64'd1 : 64'd0);
			cmd.win_start = trk_head;
			cmd.win_end = seq;
			if (needed >= 1 && 64'(trk_count) == needed - 1) begin
				cmd.act = ACT_RECOVER;
				cmd.lost_off = trk_lost;
				if (trk_lost < cfg_img) begin
					left = 64'(cfg_img - trk_lost);
					cmd.lost_len = (left < 64'(cfg_seg)) ? LEN_W'(left) : cfg_seg;
				end
			end else begin
				cmd.act = ACT_NOREC;
			end
			trk_count = '0;
			trk_lost = '0;
			trk_head = seq;
			trk_next = seq;
		end
		return cmd;
	endfunction

	function automatic stim_row_t pkt(input logic op, input logic [SEQ_W-1:0] seq,
			input logic [LEN_W-1:0] len);
		stim_row_t row;
		row = '0;
		row.kind = ROW_PACKET;
		row.op = op;
		row.seq = seq;
		row.len = len;
		return row;
	endfunction

	function automatic stim_row_t pkt_exp(input logic op, input logic [SEQ_W-1:0] seq,
			input logic [LEN_W-1:0] len, input action_t act, input logic [SEQ_W-1:0] ws,
			input logic [SEQ_W-1:0] we, input logic [SEQ_W-1:0] lo, input logic [LEN_W-1:0] ll);
		stim_row_t row;
		row = pkt(op, seq, len);
		row.typed = 1'b1;
		row.cmd.act = act;
		row.cmd.win_start = ws;
		row.cmd.win_end = we;
		row.cmd.lost_off = lo;
		row.cmd.lost_len = ll;
		return row;
	endfunction

	function automatic stim_row_t cfg_row(input logic [SEG_W-1:0] seg,
			input logic [WIN_W-1:0] win, input logic [IMG_W-1:0] img);
		stim_row_t row;
		row = '0;
		row.kind = ROW_CONFIG;
		row.len = seg;
		row.win = win;
		row.seq = img;
		return row;
	endfunction

	function automatic logic [63:0] pick_start(input int unsigned k, input int unsigned step);
		logic [63:0] room;
		room = OFF_MAX - 64'(k) * 64'(step);
		return 64'($urandom_range(0, (room > 64'd1048576) ? 1048576 : int'(room)));
	endfunction

	task automatic send_row(input stim_row_t row);
		int unsigned gap;
		gap = in_calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= row.op;
		seq_offset <= row.seq;
		seg_length <= row.len;
		drv_typed <= row.typed;
		drv_cmd <= row.cmd;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		n_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (n_done < n_sent) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// upper bits carry junk that the block must drop
	task automatic write_cfg(input logic [SEG_W-1:0] seg, input logic [WIN_W-1:0] win,
			input logic [IMG_W-1:0] img);
		cfg_wen <= 1'b1;
		cfg_index <= REG_SEGMENT;
		cfg_data <= {8'($urandom), seg};
		@(posedge clk);
		cfg_index <= REG_WINDOW;
		cfg_data <= {16'($urandom), win};
		@(posedge clk);
		cfg_index <= REG_IMAGE;
		cfg_data <= img;
		@(posedge clk);
		cfg_index <= REG_SPARE;
		cfg_data <= CFG_DATA_W'($urandom);
		@(posedge clk);
		cfg_wen <= 1'b0;
		cfg_seg = seg;
		cfg_win = win;
		cfg_img = img;
		n_settings++;
	endtask

	task automatic check_field(input string name, input logic [SEQ_W-1:0] want,
			input logic [SEQ_W-1:0] got);
		if (got !== want) begin
			n_errors++;
			if (n_errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		loss_cmd_t want;
		loss_cmd_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = {action, window_start, window_end, lost_offset, lost_length};
				if (loss_cmd_q.size() == 0) begin
					n_errors++;
					if (n_errors <= MAX_REPORTS)
						$display("%0t: unexpected result beat, expected none, got %0h",
							$time, got);
				end else begin
					want = loss_cmd_q.pop_front();
					check_field("action", SEQ_W'(want.act), SEQ_W'(got.act));
					check_field("window_start", want.win_start, got.win_start);
					check_field("window_end", want.win_end, got.win_end);
					check_field("lost_offset", want.lost_off, got.lost_off);
					check_field("lost_length", SEQ_W'(want.lost_len), SEQ_W'(got.lost_len));
				end
				if (got.act == ACT_RECOVER)
					n_recover++;
				else if (got.act == ACT_NOREC)
					n_norec++;
				n_done++;
			end
			if (in_valid && in_ready) begin
				want = next_loss_cmd(opcode, seq_offset, seg_length);
				if (drv_typed)
					want = drv_cmd;
				loss_cmd_q.push_back(want);
			end
		end
	end

	initial begin
		int unsigned hold;
		wait (arst_n);
		forever begin
			hold = out_calm ? 0 : $urandom_range(0, 11);
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		#4ms;
		$display("timeout with %0d of %0d results seen", n_done, n_sent);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		stim_row_t script[$];
		logic [63:0] pos, img_pick;
		int unsigned k, step, mode, drop_a, drop_b, phase_end, pick;
		logic [SEG_W-1:0] seg;
		logic [WIN_W-1:0] win;
		logic [IMG_W-1:0] img;
		logic [LEN_W-1:0] len;
		logic [SEQ_W-1:0] seq;

		// reset settings: 1024 byte segments, 4 per window, no object length
		script.push_back(pkt_exp(OP_PARITY, 0, 0, ACT_NOREC, 0, 0, 0, 0));
		script.push_back(pkt_exp(OP_DATA, 0, 1024, ACT_DATA, 0, 0, 0, 0));
		script.push_back(pkt_exp(OP_DATA, 2048, 1024, ACT_DATA, 0, 0, 0, 0));
		script.push_back(pkt_exp(OP_DATA, 3072, 1024, ACT_DATA, 0, 0, 0, 0));
		// single loss, lost segment beyond the object
		script.push_back(pkt_exp(OP_PARITY, 4096, 0, ACT_RECOVER, 0, 4096, 1024, 0));
		script.push_back(cfg_row(1024, 4, 6000));
		script.push_back(pkt_exp(OP_DATA, 4096, 1024, ACT_DATA, 0, 0, 0, 0));
		script.push_back(pkt_exp(OP_DATA, 6144, 1024, ACT_DATA, 0, 0, 0, 0));
		script.push_back(pkt_exp(OP_DATA, 7168, 1024, ACT_DATA, 0, 0, 0, 0));
		// lost segment clipped at object end
		script.push_back(pkt_exp(OP_PARITY, 8192, '1, ACT_RECOVER, 4096, 8192, 5120, 880));
		// parity behind the window head
		script.push_back(pkt_exp(OP_PARITY, 100, 0, ACT_NOREC, 8192, 100, 0, 0));
		script.push_back(pkt(OP_DATA, 12888, 16));
		// aligned jump keeps the first gap
		script.push_back(pkt(OP_DATA, 20580, 0));
		script.push_back(pkt(OP_PARITY, 28782, 0));
		// saturating next offset
		script.push_back(pkt(OP_DATA, '1, '1));
		script.push_back(pkt(OP_DATA, 0, 0));
		script.push_back(pkt(OP_PARITY, '1, '1));
		script.push_back(cfg_row('1, 8'd254, '1));
		script.push_back(pkt(OP_PARITY, 0, 0));
		script.push_back(pkt(OP_DATA, 0, '1));
		script.push_back(pkt(OP_PARITY, 16645890, 0));
		script.push_back(cfg_row(1, 1, 1));
		script.push_back(pkt(OP_PARITY, 0, 0));
		script.push_back(pkt_exp(OP_PARITY, 1, 0, ACT_RECOVER, 0, 1, 0, 1));
		// zero segment size
		script.push_back(cfg_row(0, 4, 100));
		script.push_back(pkt_exp(OP_DATA, 5, 5, ACT_DATA, 0, 0, 0, 0));
		script.push_back(pkt_exp(OP_PARITY, 50, 0, ACT_NOREC, 1, 50, 0, 0));
		// zero window size
		script.push_back(cfg_row(1024, 0, 100));
		script.push_back(pkt(OP_DATA, 9000, 1));
		script.push_back(pkt(OP_PARITY, 9000, 0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_CONFIG) begin
				settle();
				write_cfg(script[i].len, script[i].win, script[i].seq);
			end else begin
				send_row(script[i]);
			end
		end

		while (n_sent < ITEM_TARGET + script.size()) begin
			settle();
			pick = $urandom_range(0, 9);
			if (pick == 0)
				seg = SEG_W'($urandom_range(1, 8));
			else if (pick <= 4)
				seg = SEG_W'($urandom_range(16, 2048));
			else if (pick <= 6)
				seg = SEG_RST;
			else if (pick == 7)
				seg = '1;
			else if (pick == 8)
				seg = SEG_W'($urandom_range(1, 65535));
			else
				seg = ($urandom_range(0, 3) == 0) ? '0 : SEG_W'($urandom_range(1, 1500));
			pick = $urandom_range(0, 19);
			if (pick <= 11)
				win = WIN_W'($urandom_range(1, 8));
			else if (pick <= 16)
				win = WIN_W'($urandom_range(9, 32));
			else if (pick == 17)
				win = 8'd254;
			else if (pick == 18)
				win = '0;
			else
				win = WIN_W'($urandom_range(1, 254));
			k = (win == 0) ? $urandom_range(1, 4) : int'(win);
			step = (seg == 0) ? $urandom_range(1, 1000) : int'(seg);
			pos = pick_start(k, step);
			pick = $urandom_range(0, 4);
			if (pick == 0) begin
				img = '0;
			end else if (pick == 1) begin
				img = '1;
			end else if (pick == 2) begin
				img = IMG_W'($urandom);
			end else begin
				img_pick = pos + 64'($urandom_range(0, 3 * k * step));
				img = (img_pick > OFF_MAX) ? '1 : IMG_W'(img_pick);
			end
			write_cfg(seg, win, img);
			in_calm = ($urandom_range(0, 3) == 0);
			out_calm = ($urandom_range(0, 3) == 0);
			send_row(pkt(OP_PARITY, SEQ_W'(pos), LEN_W'($urandom)));
			phase_end = n_sent + $urandom_range(30, 80);
			while (n_sent < phase_end && n_sent < ITEM_TARGET + script.size()) begin
				if ($urandom_range(0, 4) == 0) begin
					// noise: stray, duplicated or far-off headers
					repeat ($urandom_range(1, 4)) begin
						if ($urandom_range(0, 1) == 0)
							seq = SEQ_W'($urandom);
						else
							seq = SEQ_W'(pos + 64'($urandom_range(0, 2 * step)) - 64'(step));
						send_row(pkt(1'($urandom), seq, LEN_W'($urandom)));
					end
				end else if (pos + 64'(k) * 64'(step) > OFF_MAX) begin
					pos = pick_start(k, step);
					send_row(pkt(OP_PARITY, SEQ_W'(pos), LEN_W'($urandom)));
				end else begin
					// one window: up to two segments lost, sometimes the parity beat too
					mode = $urandom_range(0, 9);
					drop_a = (mode >= 4 && mode <= 8) ? $urandom_range(0, k - 1) : k;
					drop_b = (mode == 8) ? $urandom_range(0, k - 1) : k;
					for (int unsigned i = 0; i < k; i++) begin
						if (i != drop_a && i != drop_b) begin
							len = ($urandom_range(0, 7) == 0) ? LEN_W'($urandom_range(0, step))
								: LEN_W'(step);
							send_row(pkt(OP_DATA, SEQ_W'(pos + 64'(i) * 64'(step)), len));
						end
					end
					pos = pos + 64'(k) * 64'(step);
					if (mode != 9)
						send_row(pkt(OP_PARITY, SEQ_W'(pos), LEN_W'($urandom)));
				end
			end
		end

		settle();
		in_calm = 1'b0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (loss_cmd_q.size() != 0) begin
			n_errors++;
			$display("%0t: %0d results still expected, got none", $time, loss_cmd_q.size());
		end
		$display("run covered %0d packet headers over %0d register settings", n_sent, n_settings);
		$display("parity outcomes: %0d recoveries, %0d unrecoverable windows", n_recover, n_norec);
		if (n_errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
